FILE: rtl/fwcfg_pkg.sv
// Package for the firmware configuration data port: table geometry, key layout,
// request codes and the structs shared by the top level and the table store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fwcfg_pkg;

  localparam int EntryCount  = 64;
  localparam int SlotBytes   = 256;

  localparam int KeyW        = 16;
  localparam int KeyBankBit  = 15;
  localparam int KeyWriteBit = 14;
  localparam int KeyIdxW     = 14;

  localparam int IdxW  = $clog2(EntryCount);
  localparam int SlotW = IdxW + 1;
  localparam int OffW  = $clog2(SlotBytes);
  localparam int LenW  = $clog2(SlotBytes + 1);
  localparam int AddrW = SlotW + OffW;

  typedef enum logic [1:0] {
    REQ_BUS_READ  = 2'd0,
    REQ_BUS_WRITE = 2'd1,
    REQ_LOAD_HDR  = 2'd2,
    REQ_LOAD_BYTE = 2'd3
  } req_type_e;

  localparam logic [1:0] BUS_OFF_CTRL = 2'd0;
  localparam logic [1:0] BUS_OFF_DATA = 2'd1;

  typedef struct packed {
    req_type_e   req_type;
    logic [1:0]  bus_offset;
    logic [15:0] bus_wdata;
    logic [15:0] entry_key;
    logic [8:0]  entry_length;
    logic        entry_writable;
    logic [7:0]  load_index;
    logic [7:0]  load_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       select_valid;
    logic       write_done;
    logic       access_error;
  } res_t;

  typedef struct packed {
    logic             hdr_we;
    logic [SlotW-1:0] hdr_slot;
    logic [LenW-1:0]  hdr_len;
    logic             hdr_wen;
    logic             byte_we;
    logic [AddrW-1:0] byte_addr;
    logic [7:0]       byte_data;
  } tbl_wr_t;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic            wen;
    logic [7:0]      data;
  } tbl_rd_t;

endpackage

`default_nettype wire

FILE: rtl/fwcfg_table.sv
// Entry table: header memory with per-entry valid flags and the byte memory.
// Reads are registered, with a bypass for a write to the same place in the same cycle.
// Depends on fwcfg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fwcfg_table (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire fwcfg_pkg::tbl_wr_t wr_i,
  input  wire [fwcfg_pkg::SlotW-1:0] rd_slot_i,
  input  wire [fwcfg_pkg::OffW-1:0]  rd_off_i,
  output fwcfg_pkg::tbl_rd_t     rd_o
);
  import fwcfg_pkg::*;

  localparam int Slots = 2 * EntryCount;

  logic [LenW:0]    hdr_mem [Slots];
  logic [7:0]       byte_mem [2**AddrW];
  logic [Slots-1:0] hdr_vld_q;

  logic [LenW:0]    hdr_rd_q;
  logic             hdr_rd_vld_q;
  logic             hdr_fwd_q;
  logic [LenW:0]    hdr_fwd_data_q;
  logic [7:0]       byte_rd_q;
  logic             byte_fwd_q;
  logic [7:0]       byte_fwd_data_q;

  logic [AddrW-1:0] rd_addr;
  logic [LenW:0]    hdr_eff;

  assign rd_addr = {rd_slot_i, rd_off_i};

  always_ff @(posedge clk_i) begin
    if (wr_i.hdr_we) begin
      hdr_mem[wr_i.hdr_slot] <= {wr_i.hdr_wen, wr_i.hdr_len};
    end
    hdr_rd_q <= hdr_mem[rd_slot_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.byte_we) begin
      byte_mem[wr_i.byte_addr] <= wr_i.byte_data;
    end
    byte_rd_q <= byte_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    hdr_fwd_data_q  <= {wr_i.hdr_wen, wr_i.hdr_len};
    byte_fwd_data_q <= wr_i.byte_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_vld_q    <= '0;
      hdr_rd_vld_q <= 1'b0;
      hdr_fwd_q    <= 1'b0;
      byte_fwd_q   <= 1'b0;
    end else begin
      if (wr_i.hdr_we) begin
        hdr_vld_q[wr_i.hdr_slot] <= 1'b1;
      end
      hdr_rd_vld_q <= hdr_vld_q[rd_slot_i];
      hdr_fwd_q    <= wr_i.hdr_we && (wr_i.hdr_slot == rd_slot_i);
      byte_fwd_q   <= wr_i.byte_we && (wr_i.byte_addr == rd_addr);
    end
  end

  always_comb begin
    if (hdr_fwd_q) begin
      hdr_eff = hdr_fwd_data_q;
    end else if (hdr_rd_vld_q) begin
      hdr_eff = hdr_rd_q;
    end else begin
      hdr_eff = '0;
    end
    rd_o.len  = hdr_eff[LenW-1:0];
    rd_o.wen  = hdr_eff[LenW];
    rd_o.data = byte_fwd_q ? byte_fwd_data_q : byte_rd_q;
  end

endmodule

`default_nettype wire

FILE: rtl/firmware_config_select_data_port_top.sv
// Top level of the firmware configuration data port: request register, access logic,
// selection state and result register. Depends on fwcfg_pkg and fwcfg_table.
//
// One request is taken in every clock cycle; busy is never raised. Each request gives
// exactly one result, strobed on result_valid_o through the request register and the
// result register, and the receiver cannot stall it. The byte memory's single read port
// is addressed from the next selection and byte offset, so its registered read lines up
// with the selection state. The table starts empty straight out of reset through
// per-entry valid flags, so no clearing pass is needed; byte contents are undefined
// until loaded.
`timescale 1ns / 1ps
`default_nettype none

module firmware_config_select_data_port_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  wire fwcfg_pkg::req_t req_i,
  output logic                result_valid_o,
  output fwcfg_pkg::res_t     res_o
);
  import fwcfg_pkg::*;

  req_t             req_q;
  logic             req_vld_q;
  res_t             res_q, res_d;
  logic             res_vld_q;

  logic             sel_vld_q, sel_vld_d;
  logic             sel_bank_q, sel_bank_d;
  logic             sel_wr_q, sel_wr_d;
  logic [IdxW-1:0]  sel_idx_q, sel_idx_d;
  logic [LenW-1:0]  off_q, off_d;

  tbl_wr_t          tbl_wr;
  tbl_rd_t          tbl_rd;
  logic [SlotW-1:0] rd_slot;
  logic [OffW-1:0]  rd_off;

  logic [SlotW-1:0] cur_slot;
  logic [SlotW-1:0] ekey_slot;
  logic             ekey_in_range;
  logic             wkey_in_range;
  logic             off_lt_len;
  logic [LenW-1:0]  off_inc;

  assign busy = 1'b0;

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q  <= 1'b0;
      res_vld_q  <= 1'b0;
      sel_vld_q  <= 1'b1;
      sel_bank_q <= 1'b0;
      sel_wr_q   <= 1'b0;
      sel_idx_q  <= '0;
      off_q      <= '0;
    end else begin
      req_vld_q  <= start && !busy;
      res_vld_q  <= req_vld_q;
      sel_vld_q  <= sel_vld_d;
      sel_bank_q <= sel_bank_d;
      sel_wr_q   <= sel_wr_d;
      sel_idx_q  <= sel_idx_d;
      off_q      <= off_d;
    end
  end

  assign cur_slot      = {sel_bank_q, sel_idx_q};
  assign ekey_slot     = {req_q.entry_key[KeyBankBit], req_q.entry_key[IdxW-1:0]};
  assign ekey_in_range = req_q.entry_key[KeyIdxW-1:0] < KeyIdxW'(EntryCount);
  assign wkey_in_range = req_q.bus_wdata[KeyIdxW-1:0] < KeyIdxW'(EntryCount);
  assign off_lt_len    = off_q < tbl_rd.len;
  assign off_inc       = off_q + LenW'(1);

  always_comb begin
    sel_vld_d  = sel_vld_q;
    sel_bank_d = sel_bank_q;
    sel_wr_d   = sel_wr_q;
    sel_idx_d  = sel_idx_q;
    off_d      = off_q;
    res_d      = '0;
    tbl_wr     = '0;

    if (req_vld_q) begin
      unique case (req_q.req_type)
        REQ_BUS_READ: begin
          if (sel_vld_q && off_lt_len) begin
            res_d.read_data = tbl_rd.data;
            off_d           = off_inc;
          end
        end
        REQ_BUS_WRITE: begin
          unique case (req_q.bus_offset)
            BUS_OFF_CTRL: begin
              off_d      = '0;
              sel_vld_d  = wkey_in_range;
              sel_bank_d = req_q.bus_wdata[KeyBankBit];
              sel_wr_d   = req_q.bus_wdata[KeyWriteBit];
              sel_idx_d  = req_q.bus_wdata[IdxW-1:0];
            end
            BUS_OFF_DATA: begin
              if (sel_wr_q && sel_vld_q && tbl_rd.wen && off_lt_len) begin
                tbl_wr.byte_we   = 1'b1;
                tbl_wr.byte_addr = {cur_slot, off_q[OffW-1:0]};
                tbl_wr.byte_data = req_q.bus_wdata[7:0];
                if (off_inc == tbl_rd.len) begin
                  res_d.write_done = 1'b1;
                  off_d            = '0;
                end else begin
                  off_d = off_inc;
                end
              end
            end
            default: begin
              res_d.access_error = 1'b1;
            end
          endcase
        end
        REQ_LOAD_HDR: begin
          if (!ekey_in_range || (req_q.entry_length > LenW'(SlotBytes)) ||
              (req_q.entry_writable && !req_q.entry_key[KeyWriteBit])) begin
            res_d.access_error = 1'b1;
          end else begin
            tbl_wr.hdr_we   = 1'b1;
            tbl_wr.hdr_slot = ekey_slot;
            tbl_wr.hdr_len  = req_q.entry_length;
            tbl_wr.hdr_wen  = req_q.entry_writable;
          end
        end
        REQ_LOAD_BYTE: begin
          if (!ekey_in_range || ({1'b0, req_q.load_index} >= LenW'(SlotBytes))) begin
            res_d.access_error = 1'b1;
          end else begin
            tbl_wr.byte_we   = 1'b1;
            tbl_wr.byte_addr = {ekey_slot, req_q.load_index[OffW-1:0]};
            tbl_wr.byte_data = req_q.load_byte;
          end
        end
        default: begin
          res_d.access_error = 1'b0;
        end
      endcase
    end

    res_d.select_valid = sel_vld_d;
  end

  // The table is addressed with the next selection so that its data lines up with the state.
  assign rd_slot = {sel_bank_d, sel_idx_d};
  assign rd_off  = off_d[OffW-1:0];

  fwcfg_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_slot_i (rd_slot),
    .rd_off_i  (rd_off),
    .rd_o      (tbl_rd)
  );

  assign result_valid_o = res_vld_q;
  assign res_o          = res_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_vld_q |=> res_vld_q)
    else $error("request processed without a result strobe");

  a_invalid_key_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sel_vld_q |-> (off_q == '0))
    else $error("byte offset moved while no valid key is selected");

  a_offset_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q <= LenW'(SlotBytes))
    else $error("byte offset beyond the slot size");

  a_done_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.write_done |-> (off_q == '0))
    else $error("completed data write did not rewind the byte offset");

  a_done_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.write_done |-> !res_q.access_error && (res_q.read_data == '0))
    else $error("completed data write reported together with other result fields");

endmodule

`default_nettype wire

FILE: tb/tb_firmware_config_select_data_port_top.sv
// Self-checking testbench for the firmware configuration data port: a shadow table
// predicts every reply, and a monitor compares the replies field by field as they come.
// Depends on fwcfg_pkg and firmware_config_select_data_port_top.
`timescale 1ns / 1ps

module tb_firmware_config_select_data_port_top;
  import fwcfg_pkg::*;

  localparam logic [15:0] KeyNone = 16'hFFFF;
  localparam logic [1:0] BUS_OFF_SPARE2 = 2'd2;
  localparam logic [1:0] BUS_OFF_SPARE3 = 2'd3;
  localparam int TableSlots = 2 * EntryCount;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_d;
  logic reply_valid;
  res_t reply;

  firmware_config_select_data_port_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_d),
    .result_valid_o (reply_valid),
    .res_o          (reply)
  );

  bit [15:0] shadow_key;
  bit [8:0]  shadow_offset;
  bit [8:0]  shadow_len [TableSlots];
  bit        shadow_wen [TableSlots];
  bit [7:0]  shadow_bytes [TableSlots * SlotBytes];
  bit        shadow_loaded [TableSlots * SlotBytes];

  res_t port_replies_due [$];
  int   fault_count = 0;
  int   replies_checked = 0;
  int   requests_sent = 0;
  int   sender_gap_pct = 10;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit key_in_table(logic [15:0] k);
    return k[KeyIdxW-1:0] < EntryCount;
  endfunction

  function automatic int table_slot(logic [15:0] k);
    return (k[KeyBankBit] ? EntryCount : 0) + int'(k[KeyIdxW-1:0]);
  endfunction

  function automatic res_t predict_port_access(req_t r);
    res_t o;
    int   s;
    int   a;
    o = '0;
    case (r.req_type)
      REQ_BUS_READ: begin
        if (shadow_key != KeyNone && key_in_table(shadow_key)) begin
          s = table_slot(shadow_key);
          if (shadow_offset < shadow_len[s]) begin
            o.read_data = shadow_bytes[s * SlotBytes + shadow_offset];
            shadow_offset++;
          end
        end
      end
      REQ_BUS_WRITE: begin
        if (r.bus_offset == BUS_OFF_CTRL) begin
          shadow_offset = '0;
          shadow_key = key_in_table(r.bus_wdata) ? r.bus_wdata : KeyNone;
        end else if (r.bus_offset == BUS_OFF_DATA) begin
          if (shadow_key[KeyWriteBit] && key_in_table(shadow_key)) begin
            s = table_slot(shadow_key);
            if (shadow_wen[s] && shadow_offset < shadow_len[s]) begin
              a = s * SlotBytes + shadow_offset;
              shadow_bytes[a] = r.bus_wdata[7:0];
              shadow_loaded[a] = 1'b1;
              shadow_offset++;
              if (shadow_offset == shadow_len[s]) begin
                o.write_done = 1'b1;
                shadow_offset = '0;
              end
            end
          end
        end else begin
          o.access_error = 1'b1;
        end
      end
      REQ_LOAD_HDR: begin
        if (!key_in_table(r.entry_key) || r.entry_length > SlotBytes ||
            (r.entry_writable && !r.entry_key[KeyWriteBit])) begin
          o.access_error = 1'b1;
        end else begin
          s = table_slot(r.entry_key);
          shadow_len[s] = r.entry_length;
          shadow_wen[s] = r.entry_writable;
        end
      end
      default: begin
        if (!key_in_table(r.entry_key) || r.load_index >= SlotBytes) begin
          o.access_error = 1'b1;
        end else begin
          a = table_slot(r.entry_key) * SlotBytes + r.load_index;
          shadow_bytes[a] = r.load_byte;
          shadow_loaded[a] = 1'b1;
        end
      end
    endcase
    o.select_valid = key_in_table(shadow_key);
    return o;
  endfunction

  // A read must never reach a byte that has not been loaded or written.
  function automatic bit read_hits_unloaded();
    int s;
    if (shadow_key == KeyNone || !key_in_table(shadow_key)) return 1'b0;
    s = table_slot(shadow_key);
    if (shadow_offset >= shadow_len[s]) return 1'b0;
    return !shadow_loaded[s * SlotBytes + shadow_offset];
  endfunction

  always @(posedge clk_i) begin
    res_t due;
    if (rst_ni) begin
      if (reply_valid) begin
        if (port_replies_due.size() == 0) begin
          fault_count++;
          $display("%0t: reply with no request outstanding: data %h sel %b done %b err %b",
                   $time, reply.read_data, reply.select_valid, reply.write_done,
                   reply.access_error);
        end else begin
          due = port_replies_due.pop_front();
          replies_checked++;
          if (reply.read_data !== due.read_data || reply.select_valid !== due.select_valid ||
              reply.write_done !== due.write_done ||
              reply.access_error !== due.access_error) begin
            fault_count++;
            $display("%0t: reply mismatch: expected data %h sel %b done %b err %b, got data %h sel %b done %b err %b",
                     $time, due.read_data, due.select_valid, due.write_done,
                     due.access_error, reply.read_data, reply.select_valid,
                     reply.write_done, reply.access_error);
          end
        end
      end
      if (start && !busy) port_replies_due.push_back(predict_port_access(req_d));
    end
  end

  function automatic logic [15:0] pick_key(bit in_table);
    logic [15:0] k;
    k = 16'($urandom);
    if (in_table) k[KeyIdxW-1:0] = 14'($urandom_range(EntryCount - 1));
    return k;
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.req_type       = req_type_e'($urandom_range(3));
    r.bus_offset     = 2'($urandom_range(3));
    r.bus_wdata      = pick_key($urandom_range(3) != 0);
    r.entry_key      = pick_key($urandom_range(3) != 0);
    r.entry_length   = ($urandom_range(3) == 0) ? 9'($urandom_range(511))
                                                : 9'($urandom_range(SlotBytes));
    r.entry_writable = 1'($urandom_range(1));
    r.load_index     = 8'($urandom_range(255));
    r.load_byte      = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic req_t make_req(req_type_e t);
    req_t r;
    r = random_request();
    r.req_type = t;
    return r;
  endfunction

  task automatic wait_accept();
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic send_request(input req_t r);
    req_t fill;
    while ($urandom_range(99) < sender_gap_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    while (r.req_type == REQ_BUS_READ && read_hits_unloaded()) begin
      fill = make_req(REQ_LOAD_BYTE);
      fill.entry_key = shadow_key;
      fill.entry_key[KeyWriteBit] = 1'($urandom_range(1));
      fill.load_index = shadow_offset[7:0];
      start <= 1'b1;
      req_d <= fill;
      wait_accept();
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_d <= r;
    wait_accept();
  endtask

  task automatic send_header(input logic [15:0] key, input logic [8:0] len, input bit wr);
    req_t r;
    r = make_req(REQ_LOAD_HDR);
    r.entry_key = key;
    r.entry_length = len;
    r.entry_writable = wr;
    send_request(r);
  endtask

  task automatic send_byte(input logic [15:0] key, input logic [7:0] idx,
                           input logic [7:0] val);
    req_t r;
    r = make_req(REQ_LOAD_BYTE);
    r.entry_key = key;
    r.load_index = idx;
    r.load_byte = val;
    send_request(r);
  endtask

  task automatic send_bus_write(input logic [1:0] off, input logic [15:0] wdata);
    req_t r;
    r = make_req(REQ_BUS_WRITE);
    r.bus_offset = off;
    r.bus_wdata = wdata;
    send_request(r);
  endtask

  task automatic send_read();
    send_request(make_req(REQ_BUS_READ));
  endtask

  task automatic wait_for_replies();
    @(negedge clk_i);
    start <= 1'b0;
    while (port_replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    req_t r;
    r = make_req(REQ_BUS_READ);
    r.bus_offset = BUS_OFF_SPARE3;
    send_request(r);
  endtask

  task automatic test_bus_errors();
    send_bus_write(BUS_OFF_SPARE2, 16'hFFFF);
    send_bus_write(BUS_OFF_SPARE3, 16'h0000);
  endtask

  task automatic test_bad_loads();
    send_header(16'h0040, 9'd4, 1'b0);
    send_header(16'h4000, 9'd257, 1'b1);
    send_header(16'h8005, 9'd1, 1'b1);
    send_byte(16'hFFFF, 8'd0, 8'hFF);
  endtask

  task automatic test_read_back();
    send_header(16'h8000, 9'd3, 1'b0);
    send_byte(16'h8000, 8'd0, 8'h00);
    send_byte(16'h8000, 8'd1, 8'hFF);
    send_byte(16'h8000, 8'd2, 8'hA5);
    send_byte(16'h8000, 8'd255, 8'hFF);
    send_bus_write(BUS_OFF_CTRL, 16'h8000);
    repeat (4) send_read();
  endtask

  task automatic test_write_channel();
    send_header(16'hC03F, 9'd2, 1'b1);
    send_bus_write(BUS_OFF_CTRL, 16'hC03F);
    send_bus_write(BUS_OFF_DATA, 16'hFF00);
    send_bus_write(BUS_OFF_DATA, 16'h00FF);
    send_read();
    send_bus_write(BUS_OFF_CTRL, 16'h803F);
    send_bus_write(BUS_OFF_DATA, 16'h1234);
    send_bus_write(BUS_OFF_CTRL, 16'h0040);
    send_read();
    send_bus_write(BUS_OFF_DATA, 16'h5678);
  endtask

  task automatic test_full_slot();
    send_header(16'h4001, 9'(SlotBytes), 1'b1);
    send_bus_write(BUS_OFF_CTRL, 16'h4001);
    repeat (SlotBytes) send_bus_write(BUS_OFF_DATA, 16'($urandom));
    send_bus_write(BUS_OFF_CTRL, 16'h0001);
    repeat (SlotBytes + 1) send_read();
  endtask

  task automatic test_random_traffic(input int gap_pct, input int count);
    int          first;
    int          len;
    logic [15:0] key;
    first = requests_sent;
    sender_gap_pct = gap_pct;
    while (requests_sent - first < count) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          key = pick_key(1'b1);
          len = $urandom_range(12);
          send_header(key, 9'(len), key[KeyWriteBit] & 1'($urandom_range(1)));
          for (int i = 0; i < len; i++)
            if ($urandom_range(4) != 0) send_byte(key, 8'(i), 8'($urandom));
          send_bus_write(BUS_OFF_CTRL, key);
          repeat (len + 1 + $urandom_range(2)) send_read();
        end
        3, 4, 5: begin
          key = pick_key(1'b1);
          key[KeyWriteBit] = 1'b1;
          len = $urandom_range(1, 12);
          send_header(key, 9'(len), 1'b1);
          send_bus_write(BUS_OFF_CTRL, key);
          repeat (len + $urandom_range(2)) send_bus_write(BUS_OFF_DATA, 16'($urandom));
          key[KeyWriteBit] = 1'($urandom_range(1));
          send_bus_write(BUS_OFF_CTRL, key);
          repeat (len + 1) send_read();
        end
        default: begin
          repeat ($urandom_range(1, 6)) send_request(random_request());
        end
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_d  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_bus_errors();
    test_bad_loads();
    test_read_back();
    test_write_channel();
    wait_for_replies();
    sender_gap_pct = 0;
    test_full_slot();
    test_random_traffic(10, 470);
    test_random_traffic(71, 470);
    test_random_traffic(0, 470);
    wait_for_replies();
    repeat (4) @(posedge clk_i);

    $display("Sent %0d requests: directed corner cases, one full slot written and read back,",
             requests_sent);
    $display("and random load, select, read and write traffic; %0d replies checked, %0d faults.",
             replies_checked, fault_count);
    if (fault_count == 0) begin
      $display("firmware_config_select_data_port_top: match");
    end else begin
      $display("firmware_config_select_data_port_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("firmware_config_select_data_port_top: mismatch");
    $finish;
  end

endmodule
